// ===== rtl/core/lrutc_pkg.sv =====
// Shared types and constants for the LRU tile cache.
`default_nettype none

package lrutc_pkg;

  // Width of the capacity register.
  localparam int unsigned CAP_W = 5;
  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Command codes on the input word.
  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REFRESH = 2'd1,
    CMD_GET     = 2'd2
  } lrutc_cmd_e;

  // Per-cell update control.
  typedef struct packed {
    logic shift;  // take key/handle from the next-younger neighbor
    logic load;   // take the load key/handle
  } lrutc_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/lru_tile_cache.sv =====
// Top level of the LRU tile cache: handshakes, occupancy, command control, cell row.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+-------------------------------------------
//   in      | in  | in_valid_i / in_ready_o    | command_i, key_i, tile_handle_i
//   out     | out | out_valid_o / out_ready_i  | hit_o, found_handle_o, evicted_valid_o,
//           |     |                            | evicted_handle_o
//   cfg     | in  | cfg_valid_i / cfg_ready_o  | cfg_active_capacity_i
//
// For each word all cells compare the key at once and the row moves by at most one
// slot at the clock edge, result registered at the same edge.
// An add that finds the occupancy above the active capacity (capacity was
// lowered) drops one oldest slot per cycle until occupancy meets capacity, then
// evicts and appends; only the first dropped handle is reported.
// Reset clears occupancy, control and the output valid; the slots need no reset.
// A new word is taken when no add is still dropping and the output register is
// free or being drained in the same cycle.
`default_nettype none

module lru_tile_cache #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned KEY_BITS    = 48,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command word
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic [KEY_BITS-1:0]               key_i,
  input  logic [HANDLE_BITS-1:0]            tile_handle_i,
  // result word
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [HANDLE_BITS-1:0]            found_handle_o,
  output logic                              evicted_valid_o,
  output logic [HANDLE_BITS-1:0]            evicted_handle_o,
  // capacity register
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lrutc_pkg::CAP_W-1:0]       cfg_active_capacity_i
);
  import lrutc_pkg::*;

  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // capacity register
  logic [CAP_W-1:0] cap_q;
  logic [CMP_W-1:0] cap_ext, cap_eff, occ_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_active_capacity_i;
    end
  end

  // zero acts as one, anything above DEPTH acts as DEPTH
  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // control state
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic                   busy_q, busy_d;
  logic                   out_valid_q, out_valid_d;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [HANDLE_BITS-1:0] ev_h_q, ev_h_d;

  // result register
  logic                   hit_q, hit_d;
  logic [HANDLE_BITS-1:0] found_q, found_d;
  logic                   evv_q, evv_d;
  logic [HANDLE_BITS-1:0] evh_q, evh_d;

  logic                   in_fire, step_en, finish;
  lrutc_cmd_e             cur_cmd;
  logic [KEY_BITS-1:0]    cur_key;
  logic [HANDLE_BITS-1:0] cur_handle;

  assign occ_ext    = CMP_W'(occ_q);
  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign step_en    = in_fire || busy_q;

  // only an add can stay busy, so the held word is always an add
  assign cur_cmd    = busy_q ? CMD_ADD : lrutc_cmd_e'(command_i);
  assign cur_key    = busy_q ? key_q : key_i;
  assign cur_handle = busy_q ? handle_q : tile_handle_i;

  // cell row wiring
  logic [KEY_BITS-1:0]    cell_key    [DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
  logic                   cell_found  [DEPTH];
  logic [HANDLE_BITS-1:0] cell_sel    [DEPTH];
  lrutc_ctrl_t            cell_ctrl   [DEPTH];
  logic                   cell_live   [DEPTH];

  logic                   chain_hit;
  logic [HANDLE_BITS-1:0] chain_handle;
  assign chain_hit    = cell_found[DEPTH-1];
  assign chain_handle = cell_sel[DEPTH-1];

  // row-level command decode
  logic                   add_shift, move_en, load_en;
  logic [OCC_W-1:0]       load_pos;
  logic [HANDLE_BITS-1:0] load_handle;
  logic [HANDLE_BITS-1:0] ev_now_h;

  // first dropped handle comes from the oldest slot, later drops keep it
  assign ev_now_h = busy_q ? ev_h_q : cell_handle[0];

  always_comb begin
    add_shift   = 1'b0;
    move_en     = 1'b0;
    load_en     = 1'b0;
    load_pos    = occ_q;
    load_handle = cur_handle;
    occ_d       = occ_q;
    busy_d      = busy_q;
    ev_h_d      = ev_h_q;
    finish      = 1'b0;
    hit_d       = 1'b0;
    found_d     = '0;
    evv_d       = 1'b0;
    evh_d       = '0;
    if (step_en) begin
      case (cur_cmd)
        CMD_ADD: begin
          if (occ_ext > cap_eff) begin
            // over capacity: drop oldest, keep going next cycle
            add_shift = 1'b1;
            occ_d     = occ_q - OCC_W'(1);
            busy_d    = 1'b1;
            ev_h_d    = ev_now_h;
          end else if (occ_ext == cap_eff) begin
            // full: evict oldest and append in the same edge
            add_shift = 1'b1;
            load_en   = 1'b1;
            load_pos  = occ_q - OCC_W'(1);
            busy_d    = 1'b0;
            finish    = 1'b1;
            evv_d     = 1'b1;
            evh_d     = ev_now_h;
          end else begin
            load_en   = 1'b1;
            occ_d     = occ_q + OCC_W'(1);
            busy_d    = 1'b0;
            finish    = 1'b1;
            evv_d     = busy_q;
            evh_d     = busy_q ? ev_h_q : '0;
          end
        end
        CMD_REFRESH, CMD_GET: begin
          finish = 1'b1;
          if (chain_hit) begin
            // close the gap and put the match at the young end
            move_en     = 1'b1;
            load_en     = 1'b1;
            load_pos    = occ_q - OCC_W'(1);
            load_handle = chain_handle;
            hit_d       = 1'b1;
            found_d     = (cur_cmd == CMD_GET) ? chain_handle : '0;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
  end

  // per-cell control
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_live[i]       = OCC_W'(i) < occ_q;
      cell_ctrl[i].load  = load_en && (OCC_W'(i) == load_pos);
      cell_ctrl[i].shift = add_shift ||
                           (move_en && cell_found[i] && (OCC_W'(i + 1) < occ_q));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]    nb_key;
    logic [HANDLE_BITS-1:0] nb_handle;
    logic                   found_in;
    logic [HANDLE_BITS-1:0] sel_in;

    if (g == DEPTH - 1) begin : g_last
      assign nb_key    = '0;
      assign nb_handle = '0;
    end else begin : g_mid
      assign nb_key    = cell_key[g+1];
      assign nb_handle = cell_handle[g+1];
    end

    if (g == 0) begin : g_first
      assign found_in = 1'b0;
      assign sel_in   = '0;
    end else begin : g_rest
      assign found_in = cell_found[g-1];
      assign sel_in   = cell_sel[g-1];
    end

    lrutc_cell #(
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (cell_ctrl[g]),
      .live_i        (cell_live[g]),
      .key_i         (cur_key),
      .load_handle_i (load_handle),
      .nb_key_i      (nb_key),
      .nb_handle_i   (nb_handle),
      .found_i       (found_in),
      .sel_handle_i  (sel_in),
      .key_o         (cell_key[g]),
      .handle_o      (cell_handle[g]),
      .found_o       (cell_found[g]),
      .sel_handle_o  (cell_sel[g])
    );
  end

  // output valid
  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // held add word and first evicted handle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q    <= key_i;
      handle_q <= tile_handle_i;
    end
    ev_h_q <= ev_h_d;
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      hit_q   <= hit_d;
      found_q <= found_d;
      evv_q   <= evv_d;
      evh_q   <= evh_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign found_handle_o   = found_q;
  assign evicted_valid_o  = evv_q;
  assign evicted_handle_o = evh_q;

endmodule

`default_nettype wire

// ===== rtl/core/lrutc_cell.sv =====
// One recency slot: stored key/handle, key compare and first-match chain stage.
`default_nettype none

module lrutc_cell #(
  parameter int unsigned KEY_BITS    = 48,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic                    clk_i,
  input  lrutc_pkg::lrutc_ctrl_t  ctrl_i,
  input  logic                    live_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [HANDLE_BITS-1:0]  load_handle_i,
  input  logic [KEY_BITS-1:0]     nb_key_i,
  input  logic [HANDLE_BITS-1:0]  nb_handle_i,
  input  logic                    found_i,
  input  logic [HANDLE_BITS-1:0]  sel_handle_i,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [HANDLE_BITS-1:0]  handle_o,
  output logic                    found_o,
  output logic [HANDLE_BITS-1:0]  sel_handle_o
);
  import lrutc_pkg::*;

  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   match;

  assign match        = live_i && (key_q == key_i);
  // oldest match wins: once found upstream, pass its handle through
  assign found_o      = found_i | match;
  assign sel_handle_o = found_i ? sel_handle_i : handle_q;

  assign key_o    = key_q;
  assign handle_o = handle_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q    <= key_i;
      handle_q <= load_handle_i;
    end else if (ctrl_i.shift) begin
      key_q    <= nb_key_i;
      handle_q <= nb_handle_i;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_lru_tile_cache.sv =====
// Self-checking testbench for the LRU tile cache: directed rows, random phases, shadow LRU list.
module tb_lru_tile_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import lrutc_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned KEY_BITS    = 48;
  localparam int unsigned HANDLE_BITS = 32;

  localparam int unsigned POOL_SIZE       = 20;
  localparam int unsigned ITEMS_PER_PHASE = 200;
  // Worst case is a few thousand words, each with a sender gap, a long
  // receiver stall and the drops of an add; this is several times that.
  localparam int unsigned CYCLE_LIMIT     = 400000;
  // A lowered-capacity add drops one slot per cycle; this covers DEPTH drops.
  localparam int unsigned DRAIN_CYCLES    = DEPTH + 8;

  // Command 3 has no enum member; the cache must treat it as a no-op.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;

  localparam key_t    KEY_MAX = '1;
  localparam handle_t HDL_MAX = '1;

  typedef struct packed {
    logic    hit;
    handle_t found_handle;
    logic    evicted_valid;
    handle_t evicted_handle;
  } lru_result_t;

  localparam lru_result_t RES_NONE = '0;

  // Directed rows are either a command word or a capacity write.
  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        cmd;
    key_t              key;
    handle_t           handle;
    bit                typed;   // res holds a hand-written result
    lru_result_t       res;
    logic [CAP_W-1:0]  cap;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic             clk_i                 = 1'b0;
  logic             rst_ni                = 1'b0;
  logic             in_valid_i            = 1'b0;
  logic             in_ready_o;
  logic [1:0]       command_i             = '0;
  key_t             key_i                 = '0;
  handle_t          tile_handle_i         = '0;
  logic             out_valid_o;
  logic             out_ready_i           = 1'b0;
  logic             hit_o;
  handle_t          found_handle_o;
  logic             evicted_valid_o;
  handle_t          evicted_handle_o;
  logic             cfg_valid_i           = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_active_capacity_i = '0;

  lru_tile_cache #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .command_i            (command_i),
    .key_i                (key_i),
    .tile_handle_i        (tile_handle_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .hit_o                (hit_o),
    .found_handle_o       (found_handle_o),
    .evicted_valid_o      (evicted_valid_o),
    .evicted_handle_o     (evicted_handle_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_active_capacity_i(cfg_active_capacity_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow LRU list: index 0 is the oldest entry, the back is the newest
  // ---------------------------------------------------------------------------
  key_t             lru_keys[$];
  handle_t          lru_handles[$];
  logic [CAP_W-1:0] lru_capacity = CAP_RESET;

  // Results owed by the cache, in acceptance order.
  lru_result_t pending_results[$];

  key_t        key_pool[POOL_SIZE];
  dir_row_t    dir_rows[$];

  int unsigned mismatches  = 0;
  int unsigned words_sent  = 0;
  int unsigned cap_writes  = 0;
  int unsigned hits_seen   = 0;
  int unsigned evicts_seen = 0;
  int unsigned cycle_count = 0;

  // Apply one command word to the shadow list and return what the cache owes.
  function automatic lru_result_t lru_apply(logic [1:0] cmd, key_t key, handle_t hdl);
    lru_result_t r;
    int          cap;
    int          pos;
    handle_t     h;
    r   = RES_NONE;
    pos = -1;
    // capacity 0 behaves as 1, anything above DEPTH as DEPTH
    cap = int'(lru_capacity);
    if (cap < 1) cap = 1;
    if (cap > int'(DEPTH)) cap = DEPTH;
    case (cmd)
      CMD_ADD: begin
        // Make room; after a capacity drop several entries go, only the
        // oldest one is reported.
        while (lru_keys.size() >= cap && lru_keys.size() > 0) begin
          if (!r.evicted_valid) begin
            r.evicted_valid  = 1'b1;
            r.evicted_handle = lru_handles[0];
          end
          void'(lru_keys.pop_front());
          void'(lru_handles.pop_front());
        end
        if (lru_keys.size() < int'(DEPTH)) begin
          lru_keys.push_back(key);
          lru_handles.push_back(hdl);
        end
      end
      CMD_REFRESH, CMD_GET: begin
        // duplicates: the oldest match wins
        foreach (lru_keys[i]) begin
          if (pos < 0 && lru_keys[i] == key) pos = i;
        end
        if (pos >= 0) begin
          h = lru_handles[pos];
          lru_keys.delete(pos);
          lru_handles.delete(pos);
          lru_keys.push_back(key);
          lru_handles.push_back(h);
          r.hit = 1'b1;
          if (cmd == CMD_GET) r.found_handle = h;
        end
      end
      default: ;  // unused command: no state change, all-zero result
    endcase
    return r;
  endfunction

  function automatic void dir_word(logic [1:0] cmd, key_t key, handle_t hdl, bit typed,
                                   lru_result_t res);
    dir_row_t row;
    row        = '0;
    row.kind   = ROW_WORD;
    row.cmd    = cmd;
    row.key    = key;
    row.handle = hdl;
    row.typed  = typed;
    row.res    = res;
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_cap(logic [CAP_W-1:0] cap);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CAP;
    row.cap  = cap;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: payload changes at the falling edge, valid holds until accepted
  // ---------------------------------------------------------------------------
  task automatic send_word(logic [1:0] cmd, key_t key, handle_t hdl, bit typed,
                           lru_result_t res);
    lru_result_t predicted;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    key_i         <= key;
    tile_handle_i <= hdl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // shadow list always advances, even when the row carries its own result
    predicted = lru_apply(cmd, key, hdl);
    pending_results.push_back(typed ? res : predicted);
    words_sent++;
  endtask

  task automatic pause_input(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Capacity writes happen only with the cache drained and quiet.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    pause_input(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i           <= 1'b1;
    cfg_active_capacity_i <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lru_capacity = cap;
    cap_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Keys mostly come from a small pool sized to the capacity, so refresh and
  // get hit often and duplicates build up; the rest are fully random.
  function automatic key_t pick_key(int unsigned span);
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(span - 1)];
    return key_t'({$urandom(), $urandom()});
  endfunction

  function automatic handle_t pick_handle();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return HDL_MAX;
    return handle_t'($urandom());
  endfunction

  function automatic logic [1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 42) return CMD_ADD;
    if (r < 62) return CMD_REFRESH;
    if (r < 98) return CMD_GET;
    return CMD_UNUSED;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches between modes of differing stall density
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(3) != 0);
      2:       out_ready_i <= ($urandom_range(9) < 3);
      default: out_ready_i <= ($urandom_range(9) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, handle_t want, handle_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    lru_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing pending", $time);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit",            handle_t'(want.hit),           handle_t'(hit_o));
        check_field("found_handle",   want.found_handle,             found_handle_o);
        check_field("evicted_valid",  handle_t'(want.evicted_valid), handle_t'(evicted_valid_o));
        check_field("evicted_handle", want.evicted_handle,           evicted_handle_o);
        if (hit_o === 1'b1) hits_seen++;
        if (evicted_valid_o === 1'b1) evicts_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic [CAP_W-1:0] phase_caps[10];

  initial begin : stimulus
    int unsigned span;
    int unsigned eff;
    int unsigned sent;
    int unsigned burst;

    key_pool[0] = '0;
    key_pool[1] = KEY_MAX;
    for (int i = 2; i < int'(POOL_SIZE); i++) key_pool[i] = key_t'({$urandom(), $urandom()});

    // extremes first, then a random mix; 0, 17 and 31 are out of range on purpose
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd7, 5'd17, 5'd16,
                   CAP_W'($urandom_range(31)), 5'd3};

    // Directed rows. Cache starts empty at capacity 16.
    dir_word(CMD_GET,     '0,      HDL_MAX,       1, RES_NONE);  // miss on empty
    dir_word(CMD_REFRESH, KEY_MAX, '0,            1, RES_NONE);
    dir_word(CMD_UNUSED,  48'h1234_5678_9abc, 32'hdead_beef, 1, RES_NONE);
    dir_word(CMD_ADD,     '0,      '0,            1, RES_NONE);
    dir_word(CMD_ADD,     KEY_MAX, HDL_MAX,       1, RES_NONE);
    dir_word(CMD_GET,     KEY_MAX, '0,            1, {1'b1, HDL_MAX, 1'b0, 32'h0});
    dir_word(CMD_ADD,     '0,      32'h1234_5678, 1, RES_NONE);  // duplicate key
    // oldest copy of key 0 holds handle 0
    dir_word(CMD_GET,     '0,      '0,            1, {1'b1, 32'h0, 1'b0, 32'h0});
    dir_word(CMD_GET,     '0,      '0,            0, RES_NONE);
    dir_word(CMD_REFRESH, KEY_MAX, HDL_MAX,       0, RES_NONE);
    dir_word(CMD_GET,     48'h5,   '0,            1, RES_NONE);  // plain miss
    // capacity 0 acts as 1 and sits below occupancy: next add drops three
    dir_cap(5'd0);
    dir_word(CMD_ADD,     48'h1,   32'haaaa_5555, 0, RES_NONE);
    dir_word(CMD_ADD,     48'h2,   32'h5555_aaaa, 1, {1'b0, 32'h0, 1'b1, 32'haaaa_5555});
    dir_word(CMD_GET,     48'h1,   '0,            1, RES_NONE);
    dir_word(CMD_REFRESH, 48'h2,   '0,            0, RES_NONE);
    dir_cap(5'd2);
    dir_word(CMD_ADD,     48'h3,   32'h0000_0003, 0, RES_NONE);
    dir_word(CMD_ADD,     48'h4,   32'h0000_0004, 0, RES_NONE);
    dir_word(CMD_GET,     48'h3,   '0,            0, RES_NONE);
    dir_word(CMD_ADD,     48'h5,   32'h0000_0005, 0, RES_NONE);
    // above DEPTH acts as DEPTH
    dir_cap(5'd31);
    dir_word(CMD_ADD,     48'h6,   32'h8000_0001, 0, RES_NONE);
    dir_word(CMD_GET,     48'h5,   '0,            0, RES_NONE);
    dir_word(CMD_REFRESH, 48'h6,   '0,            0, RES_NONE);
    dir_word(CMD_UNUSED,  48'h6,   32'hffff_0000, 0, RES_NONE);

    // Reset held low from time zero, released on a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        write_capacity(dir_rows[i].cap);
      end else begin
        send_word(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].handle,
                  dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random phases; each capacity write also drains the cache completely.
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      eff  = (phase_caps[p] == 0) ? 1 : ((phase_caps[p] > DEPTH) ? DEPTH : phase_caps[p]);
      span = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < int'(burst) && sent < ITEMS_PER_PHASE; b++) begin
          send_word(pick_cmd(), pick_key(span), pick_handle(), 0, RES_NONE);
          sent++;
        end
        if ($urandom_range(3) != 0) pause_input($urandom_range(1, 6));
      end
    end

    pause_input(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d command words across %0d capacity settings", words_sent, cap_writes);
    $display("saw %0d hits and %0d eviction reports", hits_seen, evicts_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lrutc_pkg.sv
rtl/core/lrutc_cell.sv
rtl/core/lru_tile_cache.sv
dv/tb_lru_tile_cache.sv
